// File: design/wsc_pkg.sv
// Shared types and constants for the waveform shape classifier.
package wsc_pkg;

  localparam int SAMPLE_W = 10;
  localparam int COUNT_W = 9;
  localparam int LIMIT_W = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [SAMPLE_W-1:0] CROSSING_LEVEL_RST = 10'd480;
  localparam logic [LIMIT_W-1:0] RECORD_LIMIT_RST = 9'd5;

  localparam logic [CFG_INDEX_W-1:0] CFG_CROSSING_LEVEL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RECORD_LIMIT = 2'd1;

  typedef enum logic [1:0] {
    SHAPE_UNKNOWN    = 2'd0,
    SHAPE_TRIANGULAR = 2'd1,
    SHAPE_SQUARE     = 2'd2,
    SHAPE_SINE       = 2'd3
  } shape_t;

  typedef struct packed {
    shape_t             shape;
    logic [COUNT_W-1:0] peaks;
    logic [COUNT_W-1:0] crossings;
    logic [COUNT_W-1:0] records;
  } result_t;

endpackage

// File: design/waveform_shape_classifier.sv
// Top level: window shape classifier with input register, window state and result buffer.
// The last sample of a window passes the input register before its result is registered.
// Throughput: one sample per cycle; an output register and one skid entry hold results, so
// only a window end stalls, and only while both are full.
// Reset (rst, synchronous): clears window state and valid flags, loads crossing_level = 480
// and record_peak_limit = 5.
module waveform_shape_classifier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wsc_pkg::SAMPLE_W-1:0]      sample,
  input  logic                              last_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        shape_code,
  output logic [wsc_pkg::COUNT_W-1:0]       peak_count,
  output logic [wsc_pkg::COUNT_W-1:0]       crossing_count,
  output logic [wsc_pkg::COUNT_W-1:0]       record_peak_count,
  input  logic                              cfg_write,
  input  logic [wsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [wsc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration
  logic [wsc_pkg::SAMPLE_W-1:0] crossing_level;
  logic [wsc_pkg::LIMIT_W-1:0]  record_peak_limit;

  // input register
  logic                         s1_valid;
  logic [wsc_pkg::SAMPLE_W-1:0] s1_sample;
  logic                         s1_last;

  // window state
  logic [wsc_pkg::SAMPLE_W-1:0] previous_sample;
  logic [wsc_pkg::SAMPLE_W-1:0] sample_before_previous;
  logic [1:0]                   samples_seen;
  logic [wsc_pkg::COUNT_W-1:0]  peaks_so_far;
  logic [wsc_pkg::COUNT_W-1:0]  crossings_so_far;
  logic [wsc_pkg::COUNT_W-1:0]  records_so_far;
  logic [wsc_pkg::SAMPLE_W-1:0] record_height;

  // result buffer
  wsc_pkg::result_t out_res;
  wsc_pkg::result_t skid_res;
  logic             skid_valid;

  logic                         s1_go;
  logic                         push;
  logic                         out_take;
  logic                         is_crossing;
  logic                         is_peak;
  logic                         is_record;
  logic [wsc_pkg::COUNT_W-1:0]  peaks_next;
  logic [wsc_pkg::COUNT_W-1:0]  crossings_next;
  logic [wsc_pkg::COUNT_W-1:0]  records_next;
  wsc_pkg::result_t             res_next;

  // a window end needs a free buffer slot; other samples always advance
  assign s1_go    = s1_valid & (~s1_last | ~skid_valid);
  assign push     = s1_go & s1_last;
  assign in_stall = s1_valid & ~s1_go;
  assign out_take = out_valid & ~out_stall;

  always_comb begin
    is_crossing = (samples_seen != 2'd0) &&
                  ((previous_sample < crossing_level) != (s1_sample < crossing_level));
    is_peak     = (samples_seen == 2'd2) && (previous_sample > sample_before_previous) &&
                  (previous_sample > s1_sample);
    is_record   = is_peak && (previous_sample > record_height);

    crossings_next = crossings_so_far;
    if (is_crossing && crossings_so_far != wsc_pkg::COUNT_MAX) begin
      crossings_next = crossings_so_far + 1'b1;
    end
    peaks_next = peaks_so_far;
    if (is_peak && peaks_so_far != wsc_pkg::COUNT_MAX) begin
      peaks_next = peaks_so_far + 1'b1;
    end
    records_next = records_so_far;
    if (is_record && records_so_far != wsc_pkg::COUNT_MAX) begin
      records_next = records_so_far + 1'b1;
    end

    res_next.peaks     = peaks_next;
    res_next.crossings = crossings_next;
    res_next.records   = records_next;
    if (records_next > record_peak_limit) begin
      res_next.shape = wsc_pkg::SHAPE_UNKNOWN;
    end else if (peaks_next >= crossings_next) begin
      res_next.shape = wsc_pkg::SHAPE_TRIANGULAR;
    end else if (peaks_next == '0) begin
      res_next.shape = wsc_pkg::SHAPE_SQUARE;
    end else begin
      res_next.shape = wsc_pkg::SHAPE_SINE;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      crossing_level    <= wsc_pkg::CROSSING_LEVEL_RST;
      record_peak_limit <= wsc_pkg::RECORD_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        wsc_pkg::CFG_CROSSING_LEVEL: crossing_level <= cfg_data[wsc_pkg::SAMPLE_W-1:0];
        wsc_pkg::CFG_RECORD_LIMIT:   record_peak_limit <= cfg_data[wsc_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_sample <= sample;
      s1_last   <= last_sample;
    end
  end

  // window state: advance on each sample, drop back to reset at window end
  always_ff @(posedge clk) begin
    if (rst || push) begin
      previous_sample        <= '0;
      sample_before_previous <= '0;
      samples_seen           <= 2'd0;
      peaks_so_far           <= '0;
      crossings_so_far       <= '0;
      records_so_far         <= '0;
      record_height          <= '0;
    end else if (s1_go) begin
      sample_before_previous <= previous_sample;
      previous_sample        <= s1_sample;
      if (samples_seen != 2'd2) begin
        samples_seen <= samples_seen + 2'd1;
      end
      peaks_so_far     <= peaks_next;
      crossings_so_far <= crossings_next;
      records_so_far   <= records_next;
      if (is_record) begin
        record_height <= previous_sample;
      end
    end
  end

  // result buffer: output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (push) begin
        out_res <= res_next;
      end
    end else if (push) begin
      skid_res <= res_next;
    end
  end

  assign shape_code        = out_res.shape;
  assign peak_count        = out_res.peaks;
  assign crossing_count    = out_res.crossings;
  assign record_peak_count = out_res.records;

endmodule

// File: design/wsc_checker.sv
// Port-level checker for the waveform shape classifier, bound to the top level.
module wsc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [1:0]                      shape_code,
  input logic [wsc_pkg::COUNT_W-1:0]     peak_count,
  input logic [wsc_pkg::COUNT_W-1:0]     crossing_count,
  input logic [wsc_pkg::COUNT_W-1:0]     record_peak_count
);

  // a stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(shape_code) && $stable(peak_count) &&
      $stable(crossing_count) && $stable(record_peak_count))
    else $error("result changed while stalled");

  // every record peak is also a peak
  a_records_le_peaks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> record_peak_count <= peak_count)
    else $error("record count above peak count");

  a_triangular: assert property (@(posedge clk) disable iff (rst)
    out_valid && shape_code == wsc_pkg::SHAPE_TRIANGULAR |-> peak_count >= crossing_count)
    else $error("triangular with fewer peaks than crossings");

  a_square: assert property (@(posedge clk) disable iff (rst)
    out_valid && shape_code == wsc_pkg::SHAPE_SQUARE |->
      peak_count == '0 && crossing_count != '0)
    else $error("square code with inconsistent counts");

  a_sine: assert property (@(posedge clk) disable iff (rst)
    out_valid && shape_code == wsc_pkg::SHAPE_SINE |->
      peak_count != '0 && peak_count < crossing_count)
    else $error("sine code with inconsistent counts");

endmodule

bind waveform_shape_classifier wsc_checker u_wsc_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .shape_code        (shape_code),
  .peak_count        (peak_count),
  .crossing_count    (crossing_count),
  .record_peak_count (record_peak_count)
);
